// ===== hw/rtl/sorted_insert_priority_queue_assert.svh =====
// Assertion macros for the sorted-insert priority queue.
// Depends on nothing; the including module supplies clk and rst.
`ifndef SORTED_INSERT_PRIORITY_QUEUE_ASSERT_SVH
`define SORTED_INSERT_PRIORITY_QUEUE_ASSERT_SVH
`ifndef SYNTH
// Checked on every clock edge outside reset.
`define SIPQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked on every clock edge, reset included.
`define SIPQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SIPQ_ASSERT(lbl, prop, msg)
`define SIPQ_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ===== hw/rtl/sipq_pkg.sv =====
// Shared types and constants for the sorted-insert priority queue.
// Depends on nothing; used by sipq_cell and the top level.
package sipq_pkg;

  // Width and reset value of the capacity register.
  localparam int CAP_W = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // Command codes.
  localparam logic CMD_ENQ = 1'b0;
  localparam logic CMD_DEQ = 1'b1;

  // Status codes reported with every result beat.
  typedef enum logic [1:0] {
    STATUS_DONE  = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_t;

  // Per-cycle command broadcast to every cell of the chain.
  typedef struct packed {
    logic ins;
    logic deq;
  } cell_ctrl_t;

endpackage

// ===== hw/rtl/sipq_cell.sv =====
// One slot of the sorted shift chain: holds a priority and a character.
// Depends on sipq_pkg for the control struct.
module sipq_cell #(
  parameter int PRIO_BITS = 8
) (
  input  logic                  clk,
  input  sipq_pkg::cell_ctrl_t  ctrl,
  input  logic                  occupied,
  input  logic                  at_tail,
  input  logic [PRIO_BITS-1:0]  new_prio,
  input  logic [7:0]            new_char,
  input  logic                  left_gt,
  input  logic [PRIO_BITS-1:0]  left_prio,
  input  logic [7:0]            left_char,
  input  logic [PRIO_BITS-1:0]  right_prio,
  input  logic [7:0]            right_char,
  output logic [PRIO_BITS-1:0]  prio,
  output logic [7:0]            chr,
  output logic                  gt
);

  logic [PRIO_BITS-1:0] slot_prio, slot_prio_next;
  logic [7:0]           slot_char, slot_char_next;

  // This slot holds an entry that must move behind the new one.
  assign gt = occupied && (slot_prio > new_prio);

  // Insert shifts the greater entries one place towards the tail; the first
  // slot that is greater, or the tail, takes the new entry. Removal shifts
  // every entry one place towards the head.
  always_comb begin
    slot_prio_next = slot_prio;
    slot_char_next = slot_char;
    if (ctrl.ins) begin
      if (left_gt) begin
        slot_prio_next = left_prio;
        slot_char_next = left_char;
      end else if (gt || at_tail) begin
        slot_prio_next = new_prio;
        slot_char_next = new_char;
      end
    end else if (ctrl.deq) begin
      slot_prio_next = right_prio;
      slot_char_next = right_char;
    end
  end

  always_ff @(posedge clk) begin
    slot_prio <= slot_prio_next;
    slot_char <= slot_char_next;
  end

  assign prio = slot_prio;
  assign chr  = slot_char;

endmodule

// ===== hw/rtl/sorted_insert_priority_queue.sv =====
// Sorted-insert priority queue built as a chain of DEPTH shifting cells.
// The result beat is registered and appears in the cycle after the access is accepted.
// Throughput: one access per cycle; every cell of the chain shifts together.
// busy is high only while rst is held; the result beat cannot be stalled.
// Reset empties the queue and sets capacity to 16; slot contents stay undefined.
// Depends on sipq_pkg, sipq_cell and sorted_insert_priority_queue_assert.svh.
`include "sorted_insert_priority_queue_assert.svh"

module sorted_insert_priority_queue #(
  parameter int DEPTH     = 16,
  parameter int PRIO_BITS = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic                                command,
  input  logic [PRIO_BITS-1:0]                entry_prio,
  input  logic [7:0]                          entry_char,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [sipq_pkg::CAP_W-1:0]          cfg_data,
  output logic                                result_valid,
  output logic [PRIO_BITS-1:0]                out_prio,
  output logic [7:0]                          out_char,
  output logic [1:0]                          status,
  output logic [$clog2(DEPTH+1)-1:0]          count_after,
  output logic                                is_empty,
  output logic                                is_full
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (CNT_W > sipq_pkg::CAP_W) ? CNT_W : sipq_pkg::CAP_W;

  logic [sipq_pkg::CAP_W-1:0] capacity;
  logic [CNT_W-1:0]           count, count_next;
  logic [CMP_W-1:0]           cap_ext, eff_cap;
  logic                       accept, full_now;
  sipq_pkg::cell_ctrl_t       ctrl;

  logic [PRIO_BITS-1:0] prio_w  [DEPTH];
  logic [7:0]           char_w  [DEPTH];
  logic                 gt_w    [DEPTH];

  // Handshake: the block takes a beat every cycle outside reset.
  assign busy      = rst;
  assign cfg_ready = ~rst;
  assign accept    = start && !busy;

  // Capacity register.
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= sipq_pkg::CAP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      capacity <= cfg_data;
    end
  end

  // Effective capacity: zero acts as one, anything above DEPTH acts as DEPTH.
  always_comb begin
    cap_ext = CMP_W'(capacity);
    if (capacity == '0) begin
      eff_cap = CMP_W'(1);
    end else if (cap_ext > CMP_W'(DEPTH)) begin
      eff_cap = CMP_W'(DEPTH);
    end else begin
      eff_cap = cap_ext;
    end
  end

  assign full_now = CMP_W'(count) >= eff_cap;

  // Command broadcast to the chain; refused accesses leave it untouched.
  assign ctrl.ins = accept && (command == sipq_pkg::CMD_ENQ) && !full_now;
  assign ctrl.deq = accept && (command == sipq_pkg::CMD_DEQ) && (count != '0);

  always_comb begin
    count_next = count;
    if (ctrl.ins) begin
      count_next = count + CNT_W'(1);
    end else if (ctrl.deq) begin
      count_next = count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // The chain of cells; the last cell refills from itself on removal.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                 left_gt;
    logic [PRIO_BITS-1:0] left_prio, right_prio;
    logic [7:0]           left_char, right_char;

    if (i == 0) begin : g_head
      assign left_gt   = 1'b0;
      assign left_prio = '0;
      assign left_char = '0;
    end else begin : g_body
      assign left_gt   = gt_w[i-1];
      assign left_prio = prio_w[i-1];
      assign left_char = char_w[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_prio = prio_w[i];
      assign right_char = char_w[i];
    end else begin : g_inner
      assign right_prio = prio_w[i+1];
      assign right_char = char_w[i+1];
    end

    sipq_cell #(
      .PRIO_BITS (PRIO_BITS)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .occupied   (count > CNT_W'(i)),
      .at_tail    (count == CNT_W'(i)),
      .new_prio   (entry_prio),
      .new_char   (entry_char),
      .left_gt    (left_gt),
      .left_prio  (left_prio),
      .left_char  (left_char),
      .right_prio (right_prio),
      .right_char (right_char),
      .prio       (prio_w[i]),
      .chr        (char_w[i]),
      .gt         (gt_w[i])
    );
  end

  // Result strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= accept;
    end
  end

  // Result payload, captured with the access.
  always_ff @(posedge clk) begin
    if (accept) begin
      out_prio    <= ctrl.deq ? prio_w[0] : '0;
      out_char    <= ctrl.deq ? char_w[0] : '0;
      count_after <= count_next;
      is_empty    <= (count_next == '0);
      is_full     <= (CMP_W'(count_next) >= eff_cap);
      if (command == sipq_pkg::CMD_ENQ && full_now) begin
        status <= sipq_pkg::STATUS_FULL;
      end else if (command == sipq_pkg::CMD_DEQ && count == '0) begin
        status <= sipq_pkg::STATUS_EMPTY;
      end else begin
        status <= sipq_pkg::STATUS_DONE;
      end
    end
  end

  // Checks on the count, the ordering of the chain and the result timing.
  `SIPQ_ASSERT(a_count_bound, CMP_W'(count) <= CMP_W'(DEPTH), "count exceeds depth")
  `SIPQ_ASSERT(a_head_sorted, count > CNT_W'(1) |-> prio_w[0] <= prio_w[1], "head out of order")
  `SIPQ_ASSERT(a_deq_count, ctrl.deq |=> count == $past(count) - CNT_W'(1), "dequeue miscount")
  `SIPQ_ASSERT(a_result_timing, accept |=> result_valid, "result beat missing")
  `SIPQ_ASSERT(a_empty_flag, result_valid |-> is_empty == (count_after == '0), "empty flag wrong")

endmodule
